// File: rtl/assert_macros.svh
// Assertion helpers for the sampler checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define WCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a stall condition.
`define WCS_ASSERT_HOLD(lbl, clk, rst_n, stall, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) stall |=> $stable(sig)) \
		else $error(msg);

`endif

// File: rtl/wcs_pkg.sv
package wcs_pkg;

	localparam int MAX_CATEGORIES = 256;
	localparam int ADDR_W         = $clog2(MAX_CATEGORIES);
	localparam int CNT_W          = $clog2(MAX_CATEGORIES + 1);

	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 8;
	localparam int VAL_W     = 32;
	localparam int MODE_W    = 2;
	localparam int COUNT_W   = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 9;

	// Sum of all weights never overflows this width.
	localparam int SUM_W  = VAL_W + ADDR_W;
	localparam int PROD_W = 2 * VAL_W;

	localparam logic [CMD_W-1:0] CMD_LOAD_CUM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_WGT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW     = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INITIAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

	typedef struct packed {
		logic              wr_en;
		logic              wr_wgt;
		logic [ADDR_W-1:0] wr_addr;
		logic [VAL_W-1:0]  wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} tbl_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] cum;
		logic [VAL_W-1:0] wgt;
	} tbl_rsp_t;

endpackage

// File: rtl/wcs_stream_if.sv
interface wcs_req_if;
	logic                        valid;
	logic                        ready;
	logic [wcs_pkg::CMD_W-1:0]   cmd;
	logic [wcs_pkg::INDEX_W-1:0] entry_index;
	logic [wcs_pkg::VAL_W-1:0]   entry_value;
	logic [wcs_pkg::VAL_W-1:0]   random_value;
	logic                        weights_present;

	modport source (output valid, cmd, entry_index, entry_value, random_value,
		weights_present, input ready);
	modport sink (input valid, cmd, entry_index, entry_value, random_value,
		weights_present, output ready);
endinterface

interface wcs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [wcs_pkg::INDEX_W-1:0] chosen_index;

	modport source (output valid, chosen_index, input ready);
	modport sink (input valid, chosen_index, output ready);
endinterface

// File: rtl/wcs_tables.sv
module wcs_tables (
	input  logic              clk,
	input  wcs_pkg::tbl_req_t req,
	output wcs_pkg::tbl_rsp_t rsp
);

	logic [wcs_pkg::VAL_W-1:0] cum_mem [wcs_pkg::MAX_CATEGORIES];
	logic [wcs_pkg::VAL_W-1:0] wgt_mem [wcs_pkg::MAX_CATEGORIES];

	always_ff @(posedge clk) begin
		if (req.wr_en && !req.wr_wgt) begin
			cum_mem[req.wr_addr] <= req.wr_data;
		end
		rsp.cum <= cum_mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_wgt) begin
			wgt_mem[req.wr_addr] <= req.wr_data;
		end
		rsp.wgt <= wgt_mem[req.rd_addr];
	end

endmodule

// File: rtl/wcs_scale.sv
// sample = floor(rnd * sum / 2^32), split into a low and a high partial product.
module wcs_scale (
	input  logic                      clk,
	input  logic [wcs_pkg::VAL_W-1:0] rnd,
	input  logic [wcs_pkg::SUM_W-1:0] sum,
	output logic [wcs_pkg::SUM_W-1:0] sample
);

	logic [wcs_pkg::PROD_W-1:0] p_lo_s1;
	logic [wcs_pkg::SUM_W-1:0]  p_hi_s1;
	logic [wcs_pkg::SUM_W-1:0]  sample_s2;

	always_ff @(posedge clk) begin
		p_lo_s1   <= wcs_pkg::PROD_W'(rnd) * wcs_pkg::PROD_W'(sum[wcs_pkg::VAL_W-1:0]);
		p_hi_s1   <= wcs_pkg::SUM_W'(rnd)
			* wcs_pkg::SUM_W'(sum[wcs_pkg::SUM_W-1:wcs_pkg::VAL_W]);
		sample_s2 <= p_hi_s1
			+ wcs_pkg::SUM_W'(p_lo_s1[wcs_pkg::PROD_W-1:wcs_pkg::VAL_W]);
	end

	assign sample = sample_s2;

endmodule

// File: rtl/wcs_ctrl.sv
module wcs_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	wcs_req_if.sink                    req,
	wcs_rsp_if.source                  rsp,
	input  logic [wcs_pkg::MODE_W-1:0] mode,
	input  logic [wcs_pkg::CNT_W-1:0]  eff_cnt,
	output wcs_pkg::tbl_req_t          tbl_req,
	input  wcs_pkg::tbl_rsp_t          tbl_rsp,
	output logic [wcs_pkg::VAL_W-1:0]  scale_rnd,
	output logic [wcs_pkg::SUM_W-1:0]  scale_sum,
	input  logic [wcs_pkg::SUM_W-1:0]  scale_sample
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INIT = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_MUL1 = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_SRCH = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]                   state_q;
	logic [wcs_pkg::CNT_W-1:0]    rd_ptr_q;
	logic                         rd_vld_s1;
	logic [wcs_pkg::ADDR_W-1:0]   rd_idx_s1;
	logic [wcs_pkg::VAL_W-1:0]    rnd_q;
	logic [wcs_pkg::SUM_W-1:0]    sum_q;
	logic [wcs_pkg::SUM_W-1:0]    run_q;
	logic [wcs_pkg::ADDR_W-1:0]   res_q;
	logic                         out_vld_q;
	logic [wcs_pkg::INDEX_W-1:0]  out_idx_q;

	logic                         accept;
	logic                         walking;
	logic [wcs_pkg::CNT_W-1:0]    limit;
	logic [wcs_pkg::SUM_W-1:0]    run_nxt;
	logic                         init_hit;
	logic                         srch_hit;
	logic                         issue;
	logic                         walk_done;
	logic                         out_free;

	assign accept   = req.valid && (state_q == S_IDLE);
	assign walking  = (state_q == S_INIT) || (state_q == S_SUM) || (state_q == S_SRCH);
	assign limit    = (state_q == S_INIT) ? eff_cnt - 1'b1 : eff_cnt;
	assign run_nxt  = run_q + wcs_pkg::SUM_W'(tbl_rsp.wgt);
	assign init_hit = (state_q == S_INIT) && rd_vld_s1 && (tbl_rsp.cum > rnd_q);
	assign srch_hit = (state_q == S_SRCH) && rd_vld_s1 && (scale_sample < run_nxt);
	assign issue    = walking && (rd_ptr_q < limit) && !init_hit && !srch_hit;
	assign walk_done = walking && !(rd_ptr_q < limit) && !rd_vld_s1;
	assign out_free = !out_vld_q || rsp.ready;

	// Loads go straight to the tables on acceptance.
	assign tbl_req.wr_en = accept
		&& ((req.cmd == wcs_pkg::CMD_LOAD_CUM) || (req.cmd == wcs_pkg::CMD_LOAD_WGT))
		&& (wcs_pkg::CNT_W'(req.entry_index) < wcs_pkg::CNT_W'(wcs_pkg::MAX_CATEGORIES));
	assign tbl_req.wr_wgt  = (req.cmd == wcs_pkg::CMD_LOAD_WGT);
	assign tbl_req.wr_addr = wcs_pkg::ADDR_W'(req.entry_index);
	assign tbl_req.wr_data = req.entry_value;
	assign tbl_req.rd_addr = rd_ptr_q[wcs_pkg::ADDR_W-1:0];

	assign scale_rnd = rnd_q;
	assign scale_sum = sum_q;

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_vld_q;
	assign rsp.chosen_index = out_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (req.cmd == wcs_pkg::CMD_DRAW)) begin
						rd_ptr_q <= '0;
						if ((mode == wcs_pkg::MODE_INITIAL)
							|| ((mode == wcs_pkg::MODE_TRACK) && !req.weights_present)) begin
							state_q <= S_INIT;
						end else if (mode == wcs_pkg::MODE_TRACK) begin
							state_q <= S_SUM;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_INIT: begin
					if (init_hit || walk_done) begin
						state_q <= S_OUT;
					end
				end
				S_SUM: begin
					if (walk_done) begin
						rd_ptr_q <= '0;
						state_q  <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (srch_hit || walk_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q[wcs_pkg::ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				rnd_q <= req.random_value;
				sum_q <= '0;
				res_q <= '0;
			end
			S_INIT: begin
				if (init_hit) begin
					res_q <= rd_idx_s1;
				end else begin
					res_q <= wcs_pkg::ADDR_W'(eff_cnt - 1'b1);
				end
			end
			S_SUM: begin
				if (rd_vld_s1) begin
					sum_q <= sum_q + wcs_pkg::SUM_W'(tbl_rsp.wgt);
				end
				run_q <= '0;
			end
			S_SRCH: begin
				if (rd_vld_s1) begin
					run_q <= run_nxt;
				end
				if (srch_hit) begin
					res_q <= rd_idx_s1;
				end else begin
					res_q <= '0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_idx_q <= wcs_pkg::INDEX_W'(res_q);
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// File: rtl/weighted_category_sampler.sv
// Weighted category sampler. Load items (cmd 0 cumulative entry, cmd 1 weight
// entry) write one table entry each; they yield no result. A draw item (cmd 2)
// yields one chosen_index, picked by the mode register: mode 0 (and mode 3)
// answers 0; mode 1 (and mode 2 without weights) walks the cumulative table
// for the first entry above the random value, else takes the last entry in
// use; mode 2 with weights walks the weight table once to sum it, scales the
// random value by the sum in a two-stage multiplier, then walks the table
// again on the running sum, answering 0 if no entry is hit. The single read
// port of the tables gives one entry per cycle. One item is worked on at a
// time; a finished result sits in an output register, so the next item is
// taken while the result waits. Every entry below category_count must be
// loaded before a draw reads it; tables are not cleared by reset.
module weighted_category_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	wcs_req_if.sink                       sample_req,
	wcs_rsp_if.source                     sample_rsp,
	input  logic                          cfg_we,
	input  logic [wcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wcs_pkg::CFG_W-1:0]     cfg_data
);

	// Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
	logic [wcs_pkg::MODE_W-1:0]  mode_q;
	logic [wcs_pkg::COUNT_W-1:0] count_q;
	logic [wcs_pkg::CNT_W-1:0]   eff_cnt;

	wcs_pkg::tbl_req_t          tbl_req;
	wcs_pkg::tbl_rsp_t          tbl_rsp;
	logic [wcs_pkg::VAL_W-1:0]  scale_rnd;
	logic [wcs_pkg::SUM_W-1:0]  scale_sum;
	logic [wcs_pkg::SUM_W-1:0]  scale_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= wcs_pkg::MODE_FIRST;
			count_q <= wcs_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				wcs_pkg::CFG_MODE:  mode_q  <= cfg_data[wcs_pkg::MODE_W-1:0];
				wcs_pkg::CFG_COUNT: count_q <= cfg_data[wcs_pkg::COUNT_W-1:0];
				default: begin
					// drop writes to unknown registers
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// Clamp the count: zero acts as one, anything above the table depth saturates.
	always_comb begin
		if (count_q == '0) begin
			eff_cnt = wcs_pkg::CNT_W'(1);
		end else if (32'(count_q) > 32'(wcs_pkg::MAX_CATEGORIES)) begin
			eff_cnt = wcs_pkg::CNT_W'(wcs_pkg::MAX_CATEGORIES);
		end else begin
			eff_cnt = wcs_pkg::CNT_W'(count_q);
		end
	end

	// Sequencer: accepts items, walks the tables, holds the result register.
	wcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (sample_req),
		.rsp          (sample_rsp),
		.mode         (mode_q),
		.eff_cnt      (eff_cnt),
		.tbl_req      (tbl_req),
		.tbl_rsp      (tbl_rsp),
		.scale_rnd    (scale_rnd),
		.scale_sum    (scale_sum),
		.scale_sample (scale_sample)
	);

	// Cumulative and weight tables with a registered read.
	wcs_tables u_tables (
		.clk (clk),
		.req (tbl_req),
		.rsp (tbl_rsp)
	);

	// Scales the random value by the weight sum between the two walks.
	wcs_scale u_scale (
		.clk    (clk),
		.rnd    (scale_rnd),
		.sum    (scale_sum),
		.sample (scale_sample)
	);

endmodule

// File: rtl/wcs_checker.sv
`include "assert_macros.svh"

module wcs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [wcs_pkg::CMD_W-1:0]   req_cmd,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [wcs_pkg::INDEX_W-1:0] rsp_index
);

	`WCS_ASSERT(a_rsp_valid_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")
	`WCS_ASSERT_HOLD(a_rsp_data_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_index, "result item changed while stalled")
	`WCS_ASSERT(a_draw_busy, clk, arst_n, req_valid && req_ready && (req_cmd == wcs_pkg::CMD_DRAW) |=> !req_ready, "draw item did not make the block busy")
	`WCS_ASSERT(a_load_free, clk, arst_n, req_valid && req_ready && (req_cmd != wcs_pkg::CMD_DRAW) |=> req_ready, "non-draw item stalled the input")
	`WCS_ASSERT(a_rsp_after_busy, clk, arst_n, $rose(rsp_valid) |-> $past(!req_ready), "result item without a draw in progress")

endmodule

bind weighted_category_sampler wcs_checker u_wcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (sample_req.valid),
	.req_ready (sample_req.ready),
	.req_cmd   (sample_req.cmd),
	.rsp_valid (sample_rsp.valid),
	.rsp_ready (sample_rsp.ready),
	.rsp_index (sample_rsp.chosen_index)
);

// File: test/weighted_category_sampler_checker.sv
module weighted_category_sampler_checker
	import wcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	wcs_req_if                   sample_req,
	wcs_rsp_if                   sample_rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          fault_count,
	output int unsigned          picks_waiting
);

	logic [VAL_W-1:0]   cum_entry [MAX_CATEGORIES];
	logic [VAL_W-1:0]   wgt_entry [MAX_CATEGORIES];
	logic [MODE_W-1:0]  cur_mode;
	logic [COUNT_W-1:0] cur_count;
	logic [INDEX_W-1:0] picks_due [$];
	logic [INDEX_W-1:0] due;
	int unsigned        faults;

	// Index picked by a draw under the current mode and category count.
	function automatic logic [INDEX_W-1:0] predict_pick(logic [VAL_W-1:0] rnd,
		logic weighted);
		int                     n;
		int                     i;
		logic [SUM_W-1:0]       total;
		logic [SUM_W-1:0]       run;
		logic [SUM_W-1:0]       target;
		logic [SUM_W+VAL_W-1:0] product;
		n = (cur_count == 0) ? 1 :
			(cur_count > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(cur_count);
		if (cur_mode == MODE_INITIAL || (cur_mode == MODE_TRACK && !weighted)) begin
			// last entry stands for 1.0 and always matches
			for (i = 0; i < n - 1; i++)
				if (cum_entry[i] > rnd)
					return i[INDEX_W-1:0];
			return INDEX_W'(n - 1);
		end
		if (cur_mode == MODE_TRACK) begin
			total = '0;
			for (i = 0; i < n; i++)
				total += {{ADDR_W{1'b0}}, wgt_entry[i]};
			product = {{SUM_W{1'b0}}, rnd} * {{VAL_W{1'b0}}, total};
			target  = product[SUM_W+VAL_W-1:VAL_W];
			run     = '0;
			for (i = 0; i < n; i++) begin
				run += {{ADDR_W{1'b0}}, wgt_entry[i]};
				if (target < run)
					return i[INDEX_W-1:0];
			end
		end
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode  = MODE_FIRST;
			cur_count = COUNT_W'(1);
			faults    = 0;
			picks_due.delete();
			for (int k = 0; k < MAX_CATEGORIES; k++) begin
				cum_entry[k] = '0;
				wgt_entry[k] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:  cur_mode  = cfg_data[MODE_W-1:0];
					CFG_COUNT: cur_count = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (sample_rsp.valid && sample_rsp.ready) begin
				if (picks_due.size() == 0) begin
					$error("chosen_index: expected none, actual %0d",
						sample_rsp.chosen_index);
					faults++;
				end else begin
					due = picks_due.pop_front();
					if (sample_rsp.chosen_index !== due) begin
						$error("chosen_index: expected %0d, actual %0d",
							due, sample_rsp.chosen_index);
						faults++;
					end
				end
			end
			if (sample_req.valid && sample_req.ready) begin
				case (sample_req.cmd)
					CMD_LOAD_CUM: cum_entry[sample_req.entry_index] = sample_req.entry_value;
					CMD_LOAD_WGT: wgt_entry[sample_req.entry_index] = sample_req.entry_value;
					CMD_DRAW: picks_due = {picks_due,
						predict_pick(sample_req.random_value, sample_req.weights_present)};
					default: ;
				endcase
			end
		end
		fault_count   <= faults;
		picks_waiting <= picks_due.size();
	end

endmodule

// File: test/weighted_category_sampler_test.sv
module weighted_category_sampler_test;
	import wcs_pkg::*;

	// Codes the block must tolerate but that have no name in the package.
	localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int ITEM_GOAL = 1150;
	// Window of counted items in which neither side adds random stalls.
	localparam int CALM_FROM = 800;
	localparam int CALM_TO   = 950;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int unsigned          fault_count;
	int unsigned          picks_waiting;

	wcs_req_if sample_req ();
	wcs_rsp_if sample_rsp ();

	// Stimulus bookkeeping: which entries hold data, so that no draw ever
	// reads an entry that was never loaded.
	bit               cum_set    [MAX_CATEGORIES];
	bit               wgt_set    [MAX_CATEGORIES];
	logic [VAL_W-1:0] cum_shadow [MAX_CATEGORIES];
	int               live_count;
	int               items;
	bit               calm;

	weighted_category_sampler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_req (sample_req),
		.sample_rsp (sample_rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	weighted_category_sampler_checker watcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_req    (sample_req),
		.sample_rsp    (sample_rsp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fault_count   (fault_count),
		.picks_waiting (picks_waiting)
	);

	always #5 clk = ~clk;

	// Hard stop: far beyond a run where every item is a full-size tracking
	// draw that meets the longest stalls on both sides.
	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: stall about one cycle in six, never inside the calm window.
	always @(posedge clk) begin
		sample_rsp.ready <= calm || ($urandom_range(99) >= 16);
	end

	// Offer one item, with random idle cycles before it; hold it until taken.
	task automatic push_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
		logic [VAL_W-1:0] val, logic [VAL_W-1:0] rnd, logic wp);
		calm = (items >= CALM_FROM && items < CALM_TO);
		while (!calm && $urandom_range(99) < 16) begin
			sample_req.valid <= 1'b0;
			@(posedge clk);
		end
		sample_req.valid           <= 1'b1;
		sample_req.cmd             <= cmd;
		sample_req.entry_index     <= idx;
		sample_req.entry_value     <= val;
		sample_req.random_value    <= rnd;
		sample_req.weights_present <= wp;
		do @(posedge clk); while (!sample_req.ready);
		if (cmd == CMD_LOAD_CUM) begin
			cum_set[idx]    = 1'b1;
			cum_shadow[idx] = val;
		end
		if (cmd == CMD_LOAD_WGT)
			wgt_set[idx] = 1'b1;
		if (cmd != CMD_SPARE)
			items++;
	endtask

	// Drop valid and wait until every pending pick is back, then let a
	// trailing load land before touching the registers.
	task automatic settle();
		sample_req.valid <= 1'b0;
		@(posedge clk);
		while (picks_waiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write mode, then category count. Junk rides in the unused mode bits.
	task automatic set_config(logic [MODE_W-1:0] m, logic [COUNT_W-1:0] c);
		logic [CFG_W-1:0] word;
		word             = CFG_W'($urandom);
		word[MODE_W-1:0] = m;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MODE;
		cfg_data  <= word;
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_data  <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = (c == 0) ? 1 : (c > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(c);
	endtask

	function automatic logic [VAL_W-1:0] pick_weight();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom_range(32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	// Random value for a draw; sometimes right on or just under a table entry
	// to hit the strict comparison.
	function automatic logic [VAL_W-1:0] pick_draw_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return cum_shadow[ADDR_W'($urandom_range(live_count - 1))];
			3:       return cum_shadow[ADDR_W'($urandom_range(live_count - 1))] - VAL_W'(1);
			default: return $urandom;
		endcase
	endfunction

	// Load every entry in use that is still empty; on rewrite, lay down a
	// fresh rising cumulative ramp and fresh weights over the whole span.
	task automatic fill_tables(bit rewrite);
		int                i;
		longint unsigned   stride;
		longint unsigned   level;
		stride = 64'h1_0000_0000 / 64'(live_count);
		for (i = 0; i < live_count; i++) begin
			if (rewrite || !cum_set[i]) begin
				level = 64'(i) * stride + 64'($urandom_range(32'(stride - 1)));
				push_item(CMD_LOAD_CUM, INDEX_W'(i), level[VAL_W-1:0], $urandom,
					1'($urandom));
			end
			if (rewrite || !wgt_set[i])
				push_item(CMD_LOAD_WGT, INDEX_W'(i), pick_weight(), $urandom,
					1'($urandom));
		end
	endtask

	initial begin
		int                 phase;
		int                 span;
		int                 roll;
		logic [MODE_W-1:0]  m;
		logic [COUNT_W-1:0] c;

		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_index                  = CFG_MODE;
		cfg_data                   = '0;
		sample_req.valid           = 1'b0;
		sample_req.cmd             = CMD_LOAD_CUM;
		sample_req.entry_index     = '0;
		sample_req.entry_value     = '0;
		sample_req.random_value    = '0;
		sample_req.weights_present = 1'b0;
		sample_rsp.ready           = 1'b0;
		live_count                 = 1;
		items                      = 0;
		calm                       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: mode first, one category, so draws answer zero
		// without reading any table. Spare command must be swallowed.
		push_item(CMD_DRAW, '0, '0, '0, 1'b0);
		push_item(CMD_DRAW, '1, '1, '1, 1'b1);
		push_item(CMD_SPARE, '1, '1, '1, 1'b1);

		// Four categories on a known ramp; weights span zero to all ones.
		settle();
		set_config(MODE_INITIAL, COUNT_W'(4));
		push_item(CMD_LOAD_CUM, INDEX_W'(0), 32'h0000_0000, '0, 1'b0);
		push_item(CMD_LOAD_CUM, INDEX_W'(1), 32'h4000_0000, '0, 1'b0);
		push_item(CMD_LOAD_CUM, INDEX_W'(2), 32'h8000_0000, '0, 1'b0);
		push_item(CMD_LOAD_CUM, INDEX_W'(3), 32'hFFFF_FFFF, '0, 1'b0);
		push_item(CMD_LOAD_WGT, INDEX_W'(0), 32'h0000_0000, '0, 1'b0);
		push_item(CMD_LOAD_WGT, INDEX_W'(1), 32'h0001_0000, '0, 1'b0);
		push_item(CMD_LOAD_WGT, INDEX_W'(2), 32'hFFFF_FFFF, '0, 1'b0);
		push_item(CMD_LOAD_WGT, INDEX_W'(3), 32'h0002_0000, '0, 1'b0);
		push_item(CMD_DRAW, '0, '0, 32'h0000_0000, 1'b0);
		push_item(CMD_DRAW, '0, '0, 32'h3FFF_FFFF, 1'b0);
		push_item(CMD_DRAW, '0, '0, 32'h4000_0000, 1'b0);
		// top of range: only the forced last entry matches
		push_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 1'b1);

		// Tracking with weights, and the fall back when weights are absent.
		settle();
		set_config(MODE_TRACK, COUNT_W'(4));
		push_item(CMD_DRAW, '0, '0, 32'h0000_0000, 1'b1);
		push_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 1'b1);
		push_item(CMD_DRAW, '0, '0, 32'h8000_0000, 1'b1);
		push_item(CMD_DRAW, '0, '0, 32'h8000_0000, 1'b0);

		// One zero weight: nothing is ever hit, answer zero.
		settle();
		set_config(MODE_TRACK, COUNT_W'(1));
		push_item(CMD_LOAD_WGT, INDEX_W'(0), '0, '0, 1'b0);
		push_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 1'b1);

		// Spare mode answers zero; count zero acts as one category.
		settle();
		set_config(MODE_SPARE, '0);
		push_item(CMD_DRAW, '0, '0, $urandom, 1'b1);
		settle();
		set_config(MODE_INITIAL, '0);
		push_item(CMD_DRAW, '0, '0, '0, 1'b0);

		// Random phases. The first three pin the count extremes: saturated
		// count on tracking, full table on initial, oversize on mode first.
		phase = 0;
		while (items < ITEM_GOAL) begin
			settle();
			case (phase)
				0: begin
					m = MODE_TRACK;
					c = 9'd511;
				end
				1: begin
					m = MODE_INITIAL;
					c = 9'd256;
				end
				2: begin
					m = MODE_FIRST;
					c = 9'd300;
				end
				default: begin
					m = ($urandom_range(19) == 0) ? MODE_SPARE
						: MODE_W'($urandom_range(MODE_TRACK));
					roll = $urandom_range(99);
					if (roll < 3)
						c = COUNT_W'(9'd256 + $urandom_range(255));
					else if (roll < 8)
						c = COUNT_W'($urandom_range(1));
					else
						c = COUNT_W'($urandom_range(2, 24));
				end
			endcase
			phase++;
			set_config(m, c);
			fill_tables(live_count <= 32 && $urandom_range(1) == 1);

			// Large counts make tracking draws slow: keep those phases short.
			span = (live_count > 32) ? 8 : $urandom_range(15, 50);
			repeat (span) begin
				roll = $urandom_range(99);
				if (roll < 65)
					push_item(CMD_DRAW, INDEX_W'($urandom), $urandom, pick_draw_value(),
						$urandom_range(9) != 0);
				else if (roll < 75)
					push_item(CMD_LOAD_CUM, INDEX_W'($urandom_range(live_count - 1)),
						$urandom, $urandom, 1'($urandom));
				else if (roll < 85)
					push_item(CMD_LOAD_WGT, INDEX_W'($urandom_range(live_count - 1)),
						pick_weight(), $urandom, 1'($urandom));
				else if (roll < 93)
					// load anywhere, even past the span in use
					push_item($urandom_range(1) ? CMD_LOAD_WGT : CMD_LOAD_CUM,
						INDEX_W'($urandom), $urandom, $urandom, 1'($urandom));
				else if (roll < 97)
					push_item(CMD_SPARE, INDEX_W'($urandom), $urandom, $urandom,
						1'($urandom));
				else
					// hold the sender until every pick is back
					settle();
			end
		end

		// Drain, then allow a full-size tracking draw's worth of cycles for
		// any stray result to show up.
		settle();
		repeat (600) @(posedge clk);
		if (fault_count == 0 && picks_waiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
